/* hw/rtl/qmn_pkg.sv */
package qmn_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned ProdW = 64;
  localparam int unsigned SumW  = 66;
  localparam int unsigned MagW  = 66;
  localparam int unsigned NewtonSteps = 5;

  typedef logic signed [WordW-1:0] word_t;

  typedef struct packed {
    word_t w;
    word_t x;
    word_t y;
    word_t z;
  } quat_t;

  typedef struct packed {
    quat_t left;
    quat_t right;
  } qmn_in_t;

  typedef struct packed {
    quat_t prod;
    logic  zero_norm;
  } qmn_out_t;

  // Floor of a 64-bit product divided by four.
  function automatic logic signed [ProdW-3:0] floor4(input logic signed [ProdW-1:0] a);
    floor4 = a[ProdW-1:2];
  endfunction

endpackage

/* hw/rtl/qmn_in_if.sv */
interface qmn_in_if
  import qmn_pkg::*;
();
  logic    valid;
  logic    ready;
  qmn_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/qmn_out_if.sv */
interface qmn_out_if
  import qmn_pkg::*;
();
  logic     valid;
  logic     ready;
  qmn_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/quaternion_multiply_normalize.sv */
// Normalized Hamilton quaternion product in signed fixed point. One quaternion pair
// is taken per cycle while the pipeline advances and passes the product, sum, length,
// scaling, square, start-value, Newton and output stages. The pipeline advances when
// its last stage is empty or its result is taken, so throughput is one item per clock
// while the output is ready; the depth is set by the five Newton steps, each of which
// spans three multiplier stages. A zero product gives zero parts and raises zero_norm.
module quaternion_multiply_normalize
  import qmn_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 30
) (
  input  logic clk_i,
  input  logic rst_ni,
  qmn_in_if.sink    in_i,
  qmn_out_if.source out_o
);

  localparam int unsigned NStages = 6 + 3 * NewtonSteps + 1;

  logic            adv;
  logic [NStages-1:0] vld_q;

  assign adv      = !vld_q[NStages-1] || out_o.ready;
  assign in_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NStages-2:0], in_i.valid};
    end
  end

  // Stage 1: 16 partial products, floored.
  logic signed [ProdW-3:0] pp_q [16];
  word_t a [4];
  word_t b [4];
  assign a[0] = in_i.data.left.w;
  assign a[1] = in_i.data.left.x;
  assign a[2] = in_i.data.left.y;
  assign a[3] = in_i.data.left.z;
  assign b[0] = in_i.data.right.w;
  assign b[1] = in_i.data.right.x;
  assign b[2] = in_i.data.right.y;
  assign b[3] = in_i.data.right.z;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          pp_q[4*i+j] <= floor4(ProdW'(a[i]) * ProdW'(b[j]));
        end
      end
    end
  end

  // Stage 2: component sums, sign and magnitude.
  logic signed [SumW-1:0] p_d [4];
  logic [MagW-1:0] mag2_q [4];
  logic [3:0]      neg2_q;

  function automatic logic signed [SumW-1:0] ex(input logic signed [ProdW-3:0] v);
    ex = SumW'(v);
  endfunction

  always_comb begin
    p_d[0] = ex(pp_q[0]) - ex(pp_q[5]) - ex(pp_q[10]) - ex(pp_q[15]);
    p_d[1] = ex(pp_q[1]) + ex(pp_q[4]) + ex(pp_q[11]) - ex(pp_q[14]);
    p_d[2] = ex(pp_q[2]) - ex(pp_q[7]) + ex(pp_q[8]) + ex(pp_q[13]);
    p_d[3] = ex(pp_q[3]) + ex(pp_q[6]) - ex(pp_q[9]) + ex(pp_q[12]);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        neg2_q[i] <= p_d[i][SumW-1];
        mag2_q[i] <= p_d[i][SumW-1] ? MagW'(-p_d[i]) : MagW'(p_d[i]);
      end
    end
  end

  // Stage 3: bit length of the largest magnitude.
  logic [MagW-1:0] or_mag;
  logic [6:0]      len_d;
  logic [MagW-1:0] mag3_q [4];
  logic [3:0]      neg3_q;
  logic [6:0]      len3_q;

  always_comb begin
    or_mag = mag2_q[0] | mag2_q[1] | mag2_q[2] | mag2_q[3];
    len_d  = '0;
    for (int i = 0; i < MagW; i++) begin
      if (or_mag[i]) len_d = 7'(i + 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mag3_q <= mag2_q;
      neg3_q <= neg2_q;
      len3_q <= len_d;
    end
  end

  // Stage 4: block scaling so the largest magnitude sits in [2^29, 2^30).
  logic [29:0] sm4_q [4];
  logic [3:0]  neg4_q;
  logic        zero4_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      neg4_q  <= neg3_q;
      zero4_q <= (len3_q == '0);
      for (int i = 0; i < 4; i++) begin
        if (len3_q > 7'd30) sm4_q[i] <= 30'(mag3_q[i] >> (len3_q - 7'd30));
        else sm4_q[i] <= 30'(mag3_q[i] << (7'd30 - len3_q));
      end
    end
  end

  // Stage 5: squares.
  logic [59:0] sq5_q [4];
  logic [29:0] sm5_q [4];
  logic [3:0]  neg5_q;
  logic        zero5_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) sq5_q[i] <= 60'(sm4_q[i]) * 60'(sm4_q[i]);
      sm5_q   <= sm4_q;
      neg5_q  <= neg4_q;
      zero5_q <= zero4_q;
    end
  end

  // Stage 6: sum of squares, operand x and start value.
  logic [61:0] s_d;
  logic [31:0] x_d;
  logic        k_d;
  logic [34:0] x5_d;

  always_comb begin
    s_d = 62'(sq5_q[0]) + 62'(sq5_q[1]) + 62'(sq5_q[2]) + 62'(sq5_q[3]);
    k_d = (s_d < (62'd1 << 60));
    x_d = k_d ? 32'(s_d >> 28) : 32'(s_d >> 30);
    x5_d = 35'(x_d) * 35'd5;
  end

  localparam int unsigned NwDepth = 3 * NewtonSteps;

  logic [31:0] x_q   [NwDepth+1];
  logic [33:0] y_q   [NwDepth+1];
  logic [63:0] tmp_q [NwDepth+1];
  logic        k_q   [NwDepth+1];
  logic [29:0] sm_q  [NwDepth+1][4];
  logic [3:0]  neg_q [NwDepth+1];
  logic        zero_q[NwDepth+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x_q[0]    <= x_d;
      y_q[0]    <= 34'h90000000 - 34'(x5_d >> 4);
      tmp_q[0]  <= '0;
      k_q[0]    <= k_d;
      sm_q[0]   <= sm5_q;
      neg_q[0]  <= neg5_q;
      zero_q[0] <= zero5_q;
    end
  end

  // Newton steps: each is y2 = y*y>>30, t = x*y2>>32, y = y*(3-t)>>31.
  for (genvar g = 0; g < NwDepth; g++) begin : g_nw
    logic [63:0] nxt;
    logic [63:0] three;
    assign three = 64'd3 << 30;
    always_comb begin
      unique case (g % 3)
        0: nxt = 64'((64'(y_q[g]) * 64'(y_q[g])) >> 30);
        1: nxt = 64'((64'(x_q[g]) * tmp_q[g][33:0]) >> 32);
        default: nxt = (tmp_q[g] >= three) ? 64'd0 : three - tmp_q[g];
      endcase
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        x_q[g+1]    <= x_q[g];
        k_q[g+1]    <= k_q[g];
        sm_q[g+1]   <= sm_q[g];
        neg_q[g+1]  <= neg_q[g];
        zero_q[g+1] <= zero_q[g];
        if (g % 3 == 2) begin
          y_q[g+1]   <= 34'((64'(y_q[g]) * nxt[31:0]) >> 31);
          tmp_q[g+1] <= '0;
        end else begin
          y_q[g+1]   <= y_q[g];
          tmp_q[g+1] <= nxt;
        end
      end
    end
  end

  // Output stage: scale, round, sign and saturate.
  localparam int unsigned ShBase = 61 - FRAC_BITS;
  logic [5:0]  sh;
  logic [63:0] r [4];
  word_t       res [4];
  qmn_out_t    out_q;

  assign sh = k_q[NwDepth] ? 6'(ShBase - 1) : 6'(ShBase);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      r[i] = (64'(sm_q[NwDepth][i]) * 64'(y_q[NwDepth]) + (64'd1 << (sh - 6'd1))) >> sh;
      if (zero_q[NwDepth]) res[i] = '0;
      else if (neg_q[NwDepth][i])
        res[i] = (r[i] > 64'h80000000) ? word_t'(32'h80000000) : word_t'(-r[i][31:0]);
      else
        res[i] = (r[i] > 64'h7FFFFFFF) ? word_t'(32'h7FFFFFFF) : word_t'(r[i][31:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.prod.w    <= res[0];
      out_q.prod.x    <= res[1];
      out_q.prod.y    <= res[2];
      out_q.prod.z    <= res[3];
      out_q.zero_norm <= zero_q[NwDepth];
    end
  end

  assign out_o.valid = vld_q[NStages-1];
  assign out_o.data  = out_q;

endmodule
